>>> hdl/maf_pkg.sv
// Shared constants and types for the moving average filter.
// No dependencies; imported by moving_average_filter and maf_div.
`default_nettype none

package maf_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W = 16;
   localparam int WLEN_W   = 6;

   // Window length register
   localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;

   // Default history depth
   localparam int DEF_MAX_WINDOW = 32;

   // Register file: byte addresses, one 32-bit word each
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WLEN = 1'b0;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } maf_div_stat_type;

endpackage

`default_nettype wire

>>> hdl/moving_average_filter.sv
// Boxcar moving average filter: sequencer, window history, running sum, CSR.
// Depends on maf_pkg, maf_ram and maf_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample, req_last_sample
//   rsp      out        rsp_valid/rsp_stall  rsp_average
//   csr      in/out     psel/penable/pready  pwrite, paddr, pwdata, prdata
//
// A sample that gives a result passes through update, divider start, the bit-serial divide
// and the output state; a sample that gives no result returns to idle after the update.
// Reset is synchronous; it restores the window length to 5 and empties the record.
// req_stall is high while a sample is in work; a waiting result in the output
// register holds the sequencer only when the next result is ready to load.
// Writing the window length clears the running sum, fill count and write position.
`default_nettype none

module moving_average_filter #(
   parameter int MAX_WINDOW = maf_pkg::DEF_MAX_WINDOW
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample stream
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                              req_last_sample,
   // average stream
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [maf_pkg::SAMPLE_W-1:0]    rsp_average,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [maf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [maf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [maf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);
   import maf_pkg::*;

   localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int EW    = (CW > WLEN_W) ? CW : WLEN_W;
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

   // Sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPD    = 3'd1;
   localparam logic [2:0] ST_DSTART = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [WLEN_W-1:0]          wlen_ff, wlen_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;

   logic                       req_beat;
   logic                       csr_write;
   logic [EW-1:0]              wlen_ext;
   logic [EW-1:0]              win;
   logic [EW-1:0]              fill_ext;
   logic [EW-1:0]              pos_ext;
   logic [AW-1:0]              pos_cur;
   logic [EW-1:0]              pos_next_ext;
   logic                       full;
   logic [SAMPLE_W-1:0]        hist_rd;
   logic signed [SUM_W-1:0]    old_ext;
   logic signed [SUM_W-1:0]    new_sum;
   logic                       out_free;
   logic                       div_start;
   maf_div_stat_type           div_stat;
   logic signed [SAMPLE_W-1:0] div_quo;

   // Handshake decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDX_WLEN) ? CSR_DATA_W'(wlen_ff) : '0;

   // Effective window: zero acts as one, clamp at the history depth
   assign wlen_ext = EW'(wlen_ff);
   always_comb begin
      if (wlen_ff == '0) begin
         win = EW'(1);
      end else if (wlen_ext > EW'(MAX_WINDOW)) begin
         win = EW'(MAX_WINDOW);
      end else begin
         win = wlen_ext;
      end
   end

   // Write position and fill state
   assign fill_ext     = EW'(fill_ff);
   assign pos_ext      = EW'(pos_ff);
   assign pos_cur      = (pos_ext >= win) ? '0 : pos_ff;
   assign pos_next_ext = EW'(pos_cur) + 1'b1;
   assign full         = (fill_ext >= win);

   // Update the running sum: drop the oldest sample once the window is full
   assign old_ext = full ? SUM_W'($signed(hist_rd)) : '0;
   assign new_sum = sum_ff - old_ext + SUM_W'(sample_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_start = (state_ff == ST_DSTART);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      wlen_in        = wlen_ff;
      sum_in         = sum_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      sample_in      = sample_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_average_in = rsp_average_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               sample_in = req_sample;
               last_in   = req_last_sample;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            sum_in = new_sum;
            pos_in = (pos_next_ext >= win) ? '0 : AW'(pos_next_ext);
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            if (full || (fill_ext + 1'b1 >= win)) begin
               state_in = ST_DSTART;
            end else begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  sum_in  = '0;
                  fill_in = '0;
                  pos_in  = '0;
               end
            end
         end
         ST_DSTART: begin
            // divider has taken the sum; end the record now if flagged
            if (last_ff) begin
               sum_in  = '0;
               fill_in = '0;
               pos_in  = '0;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = div_quo;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // register write restarts the record
      if (csr_write && (paddr[2] == CSR_IDX_WLEN)) begin
         wlen_in = pwdata[WLEN_W-1:0];
         sum_in  = '0;
         fill_in = '0;
         pos_in  = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WLEN_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      last_ff        <= last_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // Window history: read the oldest entry on accept, overwrite it in the update
   maf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (AW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPD),
      .wr_addr (pos_cur),
      .wr_data (sample_ff),
      .rd_en   (req_beat),
      .rd_addr (pos_cur),
      .rd_data (hist_rd)
   );

   // Serial divider for sum / window
   maf_div #(
      .SUM_W (SUM_W),
      .DW    (EW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (win),
      .stat     (div_stat),
      .quotient (div_quo)
   );

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ext <= win)
      else $error("fill count above window");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ext < win)
      else $error("write position outside window");

   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> (state_ff == ST_DIV))
      else $error("divider active outside divide state");

   a_beat_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_UPD))
      else $error("accepted beat did not start an update");
`endif

endmodule

`default_nettype wire

>>> hdl/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/maf_div.sv
// Radix-2 restoring divider: signed dividend by unsigned divisor, one bit a cycle.
// Depends on maf_pkg for the sample width and the status struct.
`default_nettype none

module maf_div #(
   parameter int SUM_W = 21,
   parameter int DW    = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SUM_W-1:0]       dividend,
   input  wire logic        [DW-1:0]          divisor,
   output maf_pkg::maf_div_stat_type          stat,
   output logic signed [maf_pkg::SAMPLE_W-1:0] quotient
);
   import maf_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;

   logic [DW:0]      trial;
   logic             ge;
   logic [SUM_W-1:0] mag;
   logic [SUM_W-1:0] quo_signed;

   // Magnitude of the dividend at load time
   assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Restore the sign; the quotient always fits the sample width
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[SAMPLE_W-1:0];

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire
